FILE: sv/image_row_column_projection_unit_defines.svh
// Assertion helpers for the projection unit
`ifndef IMAGE_ROW_COLUMN_PROJECTION_UNIT_DEFINES_SVH
`define IMAGE_ROW_COLUMN_PROJECTION_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("projection unit check failed");

// next-cycle implication, checked outside reset
`define IRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("projection unit check failed");

`endif

FILE: sv/irc_pkg.sv
package irc_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_BANDS_DEF = 4;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_BAND_COUNT    = 2'd2,
        REG_SAMPLE_FORMAT = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S8  = 2'd1,
        FMT_U16 = 2'd2,
        FMT_S16 = 2'd3
    } t_sample_format;

    typedef struct packed {
        logic        sum_kind;
        logic [15:0] line_index;
        logic [1:0]  band_index;
        logic [31:0] sum_value;
        logic        frame_last;
    } t_result;

    // up to two results per sample, column sum first
    typedef struct packed {
        logic    push0;
        t_result res0;
        logic    push1;
        t_result res1;
    } t_push;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_status;

endpackage

FILE: sv/irc_result_fifo.sv
module irc_result_fifo
    import irc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_push        i_push,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output t_result      o_head,
    output t_fifo_status o_status
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic [FIFO_PTR_W-1:0] n_wp;
    logic [FIFO_CNT_W-1:0] n_cnt;
    logic [1:0]            push_n;
    logic                  pop;

    assign pop    = (r_cnt != '0) && i_out_ready;
    assign push_n = {1'b0, i_push.push0} + {1'b0, i_push.push1};

    always_comb begin
        n_wp  = r_wp + FIFO_PTR_W'(push_n);
        n_cnt = r_cnt + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0 && i_push.push1) begin
            r_mem[r_wp]                      <= i_push.res0;
            r_mem[r_wp + FIFO_PTR_W'(1)]     <= i_push.res1;
        end else if (i_push.push0) begin
            r_mem[r_wp] <= i_push.res0;
        end else if (i_push.push1) begin
            r_mem[r_wp] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
            if (pop) begin
                r_rp <= r_rp + FIFO_PTR_W'(1);
            end
        end
    end

    assign o_out_valid    = (r_cnt != '0);
    assign o_head         = r_mem[r_rp];
    assign o_status.count = r_cnt;

endmodule

FILE: sv/image_row_column_projection_unit.sv
// A sample's results pass through the stage 1 registers into the output queue,
//   which hands them out at one per cycle while i_out_ready is high.
// Throughput: one sample per cycle while the output queue has room for its results.
// Column sums use a read-modify-write of one memory with a registered read and write forwarding.
// Reset (synchronous, active low): counters, stage 1 valid, row sums and queue cleared;
//   config set to 1x1, one band, u8; column memory not cleared, row 0 overwrites it.
module image_row_column_projection_unit
    import irc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [15:0]           i_sample_bits,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_sum_kind,
    output logic [15:0]           o_line_index,
    output logic [1:0]            o_band_index,
    output logic [31:0]           o_sum_value,
    output logic                  o_frame_last
);

`include "image_row_column_projection_unit_defines.svh"

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int BW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_BANDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WCW   = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;
    localparam int NCW   = ($clog2(MAX_BANDS + 1) > 3) ? $clog2(MAX_BANDS + 1) : 3;

    function automatic logic [31:0] widen(input t_sample_format fmt, input logic [15:0] raw);
        logic [31:0] v;
        case (fmt)
            FMT_U8:  v = {24'd0, raw[7:0]};
            FMT_S8:  v = {{24{raw[7]}}, raw[7:0]};
            FMT_U16: v = {16'd0, raw};
            default: v = {{16{raw[15]}}, raw};
        endcase
        return v;
    endfunction

    // configuration
    logic [12:0]    r_image_width;
    logic [15:0]    r_image_height;
    logic [2:0]     r_band_count;
    t_sample_format r_sample_format;

    // position counters
    logic [XW-1:0] r_x;
    logic [15:0]   r_y;
    logic [BW-1:0] r_b;

    // stage 1
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_idx;
    logic [XW-1:0] r_s1_x;
    logic [15:0]   r_s1_y;
    logic [BW-1:0] r_s1_b;
    logic [31:0]   r_s1_sample;
    logic          r_s1_end_row;
    logic          r_s1_last_row;
    logic          r_s1_last_band;
    logic          r_s1_fwd;
    logic [31:0]   r_s1_fwd_data;
    logic [31:0]   r_rd;

    logic [31:0] r_col_mem [DEPTH];
    logic [31:0] r_row_sums [MAX_BANDS];

    logic [WCW-1:0] w_raw, w_eff, wm1;
    logic [15:0]    hm1;
    logic [NCW-1:0] nb_raw, nb_eff, nbm1;
    logic [XW-1:0]  x_c;
    logic [BW-1:0]  b_c;
    logic [AW-1:0]  idx;
    logic           end_row, last_row, last_band;
    logic           in_accept;
    logic [31:0]    col_base, n_col, n_row;
    t_push          push;
    t_fifo_status   fifo_status;
    t_result        head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= 13'd1;
            r_image_height  <= 16'd1;
            r_band_count    <= 3'd1;
            r_sample_format <= FMT_U8;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[12:0];
                REG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[15:0];
                REG_BAND_COUNT:    r_band_count    <= i_cfg_data[2:0];
                REG_SAMPLE_FORMAT: r_sample_format <= t_sample_format'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // effective limits with out-of-range register values folded in
    always_comb begin
        w_raw = WCW'(r_image_width);
        if (w_raw == '0) begin
            w_eff = WCW'(1);
        end else if (w_raw > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        wm1 = w_eff - WCW'(1);
        hm1 = (r_image_height == '0) ? 16'd0 : r_image_height - 16'd1;
        nb_raw = NCW'(r_band_count);
        if (nb_raw == '0) begin
            nb_eff = NCW'(1);
        end else if (nb_raw > NCW'(MAX_BANDS)) begin
            nb_eff = NCW'(MAX_BANDS);
        end else begin
            nb_eff = nb_raw;
        end
        nbm1 = nb_eff - NCW'(1);
        x_c  = (r_x >= XW'(MAX_WIDTH - 1)) ? XW'(MAX_WIDTH - 1) : r_x;
        b_c  = (r_b >= BW'(MAX_BANDS - 1)) ? BW'(MAX_BANDS - 1) : r_b;
        idx  = AW'(AW'(x_c) * AW'(MAX_BANDS) + AW'(b_c));
        end_row   = WCW'(x_c) >= wm1;
        last_row  = r_y >= hm1;
        last_band = NCW'(b_c) >= nbm1;
    end

    // room for two results of the sample in stage 1 and two of the new one
    assign o_in_ready = ({1'b0, fifo_status.count} + (r_s1_valid ? (FIFO_CNT_W + 1)'(2) : '0))
                        <= (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2);
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_b        <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            if (in_accept) begin
                if (last_band) begin
                    r_b <= '0;
                    if (end_row) begin
                        r_x <= '0;
                        r_y <= last_row ? 16'd0 : r_y + 16'd1;
                    end else begin
                        r_x <= x_c + XW'(1);
                    end
                end else begin
                    r_b <= b_c + BW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx       <= idx;
            r_s1_x         <= x_c;
            r_s1_y         <= r_y;
            r_s1_b         <= b_c;
            r_s1_sample    <= widen(r_sample_format, i_sample_bits);
            r_s1_end_row   <= end_row;
            r_s1_last_row  <= last_row;
            r_s1_last_band <= last_band;
            // stage 1 writes this entry at the same edge as the read
            r_s1_fwd       <= r_s1_valid && (r_s1_idx == idx);
            r_s1_fwd_data  <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd <= r_col_mem[idx];
        end
        if (r_s1_valid) begin
            r_col_mem[r_s1_idx] <= n_col;
        end
    end

    always_comb begin
        col_base = r_s1_fwd ? r_s1_fwd_data : r_rd;
        n_col    = (r_s1_y == '0) ? r_s1_sample : col_base + r_s1_sample;
        n_row    = (r_s1_x == '0) ? r_s1_sample : r_row_sums[r_s1_b] + r_s1_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BANDS; i++) begin
                r_row_sums[i] <= '0;
            end
        end else if (r_s1_valid) begin
            r_row_sums[r_s1_b] <= n_row;
        end
    end

    always_comb begin
        push.push0           = r_s1_valid && r_s1_last_row;
        push.res0.sum_kind   = 1'b1;
        push.res0.line_index = 16'(r_s1_x);
        push.res0.band_index = 2'(r_s1_b);
        push.res0.sum_value  = n_col;
        push.res0.frame_last = 1'b0;
        push.push1           = r_s1_valid && r_s1_end_row;
        push.res1.sum_kind   = 1'b0;
        push.res1.line_index = r_s1_y;
        push.res1.band_index = 2'(r_s1_b);
        push.res1.sum_value  = n_row;
        push.res1.frame_last = r_s1_last_row && r_s1_last_band;
    end

    irc_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_head      (head),
        .o_status    (fifo_status)
    );

    assign o_sum_kind   = head.sum_kind;
    assign o_line_index = head.line_index;
    assign o_band_index = head.band_index;
    assign o_sum_value  = head.sum_value;
    assign o_frame_last = head.frame_last;

    `IRC_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_status.count <= FIFO_CNT_W'(FIFO_DEPTH))
    `IRC_ASSERT_NEXT(a_s1_follows, in_accept, r_s1_valid)
    `IRC_ASSERT_NOW(a_last_is_row, o_out_valid && o_frame_last, !o_sum_kind)

endmodule

FILE: tb/image_row_column_projection_unit_tb.sv
module image_row_column_projection_unit_tb;
    import irc_pkg::*;

    localparam int ITEM_TARGET   = 1800;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 250;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int CLAMP_ITEMS   = 200;
    localparam int ACC_AW        = $clog2(MAX_WIDTH_DEF * MAX_BANDS_DEF);
    localparam int BAND_AW       = $clog2(MAX_BANDS_DEF);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [15:0]           i_sample_bits = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_sum_kind;
    logic [15:0]           o_line_index;
    logic [1:0]            o_band_index;
    logic [31:0]           o_sum_value;
    logic                  o_frame_last;

    image_row_column_projection_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_bits (i_sample_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sum_kind    (o_sum_kind),
        .o_line_index  (o_line_index),
        .o_band_index  (o_band_index),
        .o_sum_value   (o_sum_value),
        .o_frame_last  (o_frame_last)
    );

    // shadow of the projection state and registers
    logic [31:0]    column_acc [MAX_WIDTH_DEF*MAX_BANDS_DEF];
    logic [31:0]    row_acc [MAX_BANDS_DEF];
    int unsigned    pix_x = 0;
    int unsigned    pix_y = 0;
    int unsigned    band_pos = 0;
    logic [12:0]    cfg_width = 13'd1;
    logic [15:0]    cfg_height = 16'd1;
    logic [2:0]     cfg_bands = 3'd1;
    t_sample_format cfg_format = FMT_U8;

    logic [15:0] pending_samples[$];
    t_result     expected_sums[$];
    t_result     oldest_sum;

    int unsigned issued_total = 0;
    int unsigned accepted_total = 0;
    int unsigned sums_checked = 0;
    int unsigned frames_done = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 29;
    int unsigned recv_idle_pct = 70;
    logic        out_hold = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned active_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned active_height();
        return (cfg_height == 0) ? 1 : 32'(cfg_height);
    endfunction

    function automatic int unsigned active_bands();
        if (cfg_bands == 0) return 1;
        if (cfg_bands > MAX_BANDS_DEF) return MAX_BANDS_DEF;
        return 32'(cfg_bands);
    endfunction

    // widen one sample, update row/column sums, queue the sums it completes
    task automatic project_sample(logic [15:0] raw);
        logic [31:0] val;
        logic [31:0] rsum;
        logic [31:0] csum;
        int unsigned w, h, nb, idx;
        bit end_row, last_row, last_band;
        w = active_width();
        h = active_height();
        nb = active_bands();
        case (cfg_format)
            FMT_U8:  val = {24'd0, raw[7:0]};
            FMT_S8:  val = {{24{raw[7]}}, raw[7:0]};
            FMT_U16: val = {16'd0, raw};
            default: val = {{16{raw[15]}}, raw};
        endcase
        rsum = (pix_x == 0) ? val : row_acc[BAND_AW'(band_pos)] + val;
        row_acc[BAND_AW'(band_pos)] = rsum;
        idx = pix_x * MAX_BANDS_DEF + band_pos;
        csum = (pix_y == 0) ? val : column_acc[ACC_AW'(idx)] + val;
        column_acc[ACC_AW'(idx)] = csum;
        // "at or beyond" so counters recover after a mid-frame shrink
        end_row = pix_x >= w - 1;
        last_row = pix_y >= h - 1;
        last_band = band_pos >= nb - 1;
        if (last_row)
            expected_sums.push_back(t_result'{1'b1, 16'(pix_x), 2'(band_pos), csum, 1'b0});
        if (end_row)
            expected_sums.push_back(t_result'{1'b0, 16'(pix_y), 2'(band_pos), rsum,
                                              last_row && last_band});
        if (last_band) begin
            band_pos = 0;
            if (end_row) begin
                pix_x = 0;
                pix_y = last_row ? 0 : (pix_y + 1) & 16'hFFFF;
            end else begin
                pix_x = pix_x + 1;
            end
        end else begin
            band_pos = band_pos + 1;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < 50)
            $display("MISMATCH at %0t: %s got %0h want %0h (sum #%0d)",
                     $time, what, got, want, sums_checked);
        error_count++;
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                project_sample(i_sample_bits);
                accepted_total++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_sample_bits <= pending_samples.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                sums_checked++;
                if (o_frame_last === 1'b1) frames_done++;
                if (expected_sums.size() == 0) begin
                    report_mismatch("result with nothing pending", o_sum_value, 32'd0);
                end else begin
                    oldest_sum = expected_sums.pop_front();
                    if (o_sum_kind !== oldest_sum.sum_kind)
                        report_mismatch("sum_kind", 32'(o_sum_kind),
                                        32'(oldest_sum.sum_kind));
                    if (o_line_index !== oldest_sum.line_index)
                        report_mismatch("line_index", 32'(o_line_index),
                                        32'(oldest_sum.line_index));
                    if (o_band_index !== oldest_sum.band_index)
                        report_mismatch("band_index", 32'(o_band_index),
                                        32'(oldest_sum.band_index));
                    if (o_sum_value !== oldest_sum.sum_value)
                        report_mismatch("sum_value", o_sum_value, oldest_sum.sum_value);
                    if (o_frame_last !== oldest_sum.frame_last)
                        report_mismatch("frame_last", 32'(o_frame_last),
                                        32'(oldest_sum.frame_last));
                end
            end
            i_out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d sums outstanding",
                     cycle_count, expected_sums.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_sample(logic [15:0] v);
        pending_samples.push_back(v);
        issued_total++;
    endtask

    task automatic queue_samples(int unsigned count);
        logic [15:0] v;
        for (int unsigned i = 0; i < count; i++) begin
            case ($urandom_range(7))
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                2: v = {8'($urandom), 8'h80};
                3: v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                default: v = 16'($urandom);
            endcase
            push_sample(v);
        end
    endtask

    // all requests taken, all sums back, then a settle wait for no-result samples
    task automatic wait_until_idle();
        while (accepted_total != issued_total || expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(t_reg_index idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = val[12:0];
            REG_IMAGE_HEIGHT: cfg_height = val;
            REG_BAND_COUNT:   cfg_bands = val[2:0];
            default:          cfg_format = t_sample_format'(val[1:0]);
        endcase
        @(negedge i_clk);
    endtask

    task automatic configure(logic [15:0] w, logic [15:0] h, logic [2:0] nb,
                             t_sample_format f);
        set_reg(REG_IMAGE_WIDTH, w);
        set_reg(REG_IMAGE_HEIGHT, h);
        set_reg(REG_BAND_COUNT, {13'd0, nb});
        set_reg(REG_SAMPLE_FORMAT, {14'd0, f});
    endtask

    task automatic pick_config();
        logic [15:0] w;
        logic [15:0] h;
        logic [2:0]  nb;
        w = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(12, 1));
        h = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(6, 1));
        nb = ($urandom_range(5) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
        configure(w, h, nb, t_sample_format'($urandom_range(3)));
    endtask

    initial begin
        int unsigned skip_items;
        int unsigned progress;
        bit bulk_done;
        bulk_done = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: 1x1 frame, one band, u8 -> column and row sum per sample
        push_sample(16'h00FF);
        push_sample(16'hFF00);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'h0080);
        wait_until_idle();
        configure(16'd1, 16'd1, 3'd1, FMT_S8);
        push_sample(16'h0080);
        push_sample(16'h007F);
        push_sample(16'hFF80);
        wait_until_idle();
        set_reg(REG_SAMPLE_FORMAT, {14'd0, FMT_U16});
        push_sample(16'hFFFF);
        push_sample(16'h8000);
        wait_until_idle();
        set_reg(REG_SAMPLE_FORMAT, {14'd0, FMT_S16});
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'hFFFF);
        wait_until_idle();
        // zero registers act as one
        configure(16'd0, 16'd0, 3'd0, FMT_U16);
        push_sample(16'h1234);
        push_sample(16'hA5A5);
        wait_until_idle();
        configure(16'd2, 16'd2, 3'd2, FMT_S16);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h0000);
        wait_until_idle();
        // largest sizes, then shrink in the middle of row 0
        configure(16'd4096, 16'd65535, 3'd7, FMT_U16);
        queue_samples(10);
        wait_until_idle();
        configure(16'd3, 16'd2, 3'd3, FMT_S8);
        queue_samples(12);
        wait_until_idle();

        skip_items = issued_total;
        while (issued_total - skip_items < ITEM_TARGET) begin
            progress = issued_total - skip_items;
            if (progress < ITEM_TARGET / 3) begin
                send_idle_pct <= 29;
                recv_idle_pct <= 70;
            end else if (progress < 2 * ITEM_TARGET / 3) begin
                send_idle_pct <= 70;
                recv_idle_pct <= 29;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end

            // finish a frame left open so a new config starts at pixel 0, row 0
            if (pix_x != 0 || pix_y != 0 || band_pos != 0) begin
                queue_samples(((active_height() - 1 - pix_y) * active_width()
                               + active_width() - 1 - pix_x) * active_bands()
                              + active_bands() - band_pos);
                wait_until_idle();
            end

            if (progress >= 2 * ITEM_TARGET / 3 && !bulk_done) begin
                // width above the maximum clamps; part of a single row, then shrink to close it
                configure(16'd8191, 16'd1, 3'd1, t_sample_format'($urandom_range(3)));
                queue_samples(CLAMP_ITEMS);
                bulk_done = 1;
                wait_until_idle();
                set_reg(REG_IMAGE_WIDTH, 16'(CLAMP_ITEMS + 1));
                queue_samples(1);
                wait_until_idle();
                // receiver holds off while requests keep coming
                configure(16'd4, 16'd3, 3'd2, FMT_S16);
                fork
                    begin
                        out_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        out_hold <= 1'b0;
                    end
                join_none
                queue_samples(72);
            end else if ($urandom_range(4) == 0) begin
                pick_config();
                queue_samples($urandom_range(active_width() * active_height() * active_bands(),
                                             1));
                wait_until_idle();
                // mid-frame change: only shrink width and bands, row 0 filled the rest
                configure(16'($urandom_range(active_width(), 1)), 16'($urandom_range(6)),
                          3'($urandom_range(active_bands(), 1)),
                          t_sample_format'($urandom_range(3)));
                queue_samples(active_width() * active_bands() + $urandom_range(20));
            end else begin
                pick_config();
                queue_samples($urandom_range(3, 1) * active_width() * active_height()
                              * active_bands());
            end
            wait_until_idle();
        end

        $display("projection run: %0d samples, %0d sums checked, %0d frames, %0d mismatches",
                 accepted_total, sums_checked, frames_done, error_count);
        $display("covered u8/s8/u16/s16, widths to 4096, band counts 0-7, mid-frame shrink, "
                 , "long output stall");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
